// File: rtl/kmer_bloom_filter_core_assert.svh
// Assertion macros for the k-mer Bloom filter core.
// Both forms sample on i_clk and stay quiet while i_rst_n is low.
`ifndef KMER_BLOOM_FILTER_CORE_ASSERT_SVH
`define KMER_BLOOM_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define KBF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`define KBF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define KBF_ASSERT(label, prop, msg)

`define KBF_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

// File: rtl/kbf_pkg.sv
package kbf_pkg;

    // Widths of the fixed fields
    localparam int KMER_LEN_W = 6;
    localparam int KEY_W      = 64;
    localparam int POS_W      = 16;

    // Filter memory row layout: one row holds 64 filter bits
    localparam int ROW_OFS_BITS = 6;
    localparam int ROW_BITS     = 64;

    // Output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    // k-mer length register
    localparam logic [KMER_LEN_W-1:0] KMER_LEN_RESET = 6'd25;
    localparam logic [KMER_LEN_W-1:0] KMER_LEN_MIN   = 6'd2;
    localparam logic [KMER_LEN_W-1:0] KMER_LEN_MAX   = 6'd32;

    // Position handling
    localparam logic [POS_W-1:0] POS_MAX      = 16'hFFFF;
    localparam logic [POS_W-1:0] SAMPLE_EVERY = 16'd10;
    // floor(x / 10) = (x * 52429) >> 19, exact over 16 bits
    localparam logic [31:0]      DIV10_MUL    = 32'd52429;
    localparam int               DIV10_SHIFT  = 19;

    // Base characters and their 2-bit codes
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_T = 2'd1;
    localparam logic [1:0] CODE_C = 2'd2;
    localparam logic [1:0] CODE_G = 2'd3;

    // Probe numbering and hash multipliers
    typedef logic [1:0] t_probe_idx;
    localparam t_probe_idx PROBE_FIRST = 2'd0;
    localparam t_probe_idx PROBE_MID   = 2'd1;
    localparam t_probe_idx PROBE_LAST  = 2'd2;

    localparam logic [63:0] HASH_MULT_0 = 64'd1713137323;
    localparam logic [63:0] HASH_MULT_1 = 64'd371371377;
    localparam logic [63:0] HASH_MULT_2 = 64'd7341234131;

    function automatic logic [63:0] hash_mult(input t_probe_idx idx);
        unique case (idx)
            PROBE_FIRST: return HASH_MULT_0;
            PROBE_MID:   return HASH_MULT_1;
            default:     return HASH_MULT_2;
        endcase
    endfunction

    // One base after the front end
    typedef struct packed {
        logic             kmer;
        logic             query;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        logic             sampled;
    } t_job;

    // One result word
    typedef struct packed {
        logic             kmer_ready;
        logic [KEY_W-1:0] kmer_key;
        logic [POS_W-1:0] kmer_pos;
        logic             sampled;
        logic             maybe_present;
    } t_res;

    // Probe engine status back to the front end
    typedef struct packed {
        logic job_take;
        logic clr_busy;
    } t_probe_stat;

endpackage

// File: rtl/kbf_if.sv
// Input channel: one base character per word
interface kbf_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] base_char;
    logic       read_start;

    modport source (output valid, output func, output base_char, output read_start,
                    input ready);
    modport sink   (input valid, input func, input base_char, input read_start,
                    output ready);
endinterface

// Output channel: one result word per base
interface kbf_out_if;
    logic        valid;
    logic        ready;
    logic        kmer_ready;
    logic [63:0] kmer_key;
    logic [15:0] kmer_pos;
    logic        sampled;
    logic        maybe_present;

    modport source (output valid, output kmer_ready, output kmer_key, output kmer_pos,
                    output sampled, output maybe_present, input ready);
    modport sink   (input valid, input kmer_ready, input kmer_key, input kmer_pos,
                    input sampled, input maybe_present, output ready);
endinterface

// File: rtl/kbf_front.sv
module kbf_front
    import kbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [KMER_LEN_W-1:0] i_cfg_wdata,
    input  t_probe_stat           i_stat,
    kbf_in_if.sink                i_in,
    output logic                  o_job_valid,
    output t_job                  o_job
);

    logic [KMER_LEN_W-1:0] r_kmer_len;
    logic [KEY_W-1:0]      r_rolling_key, n_rolling_key;
    logic [KMER_LEN_W-1:0] r_valid_run, n_valid_run;
    logic [POS_W-1:0]      r_base_index, n_base_index;
    logic                  r_job_valid;
    t_job                  r_job, n_job;

    logic [KMER_LEN_W-1:0] k_eff;
    logic [6:0]            two_k;
    logic [KEY_W-1:0]      key_mask;
    logic [KEY_W-1:0]      key_base;
    logic [KMER_LEN_W-1:0] run_base;
    logic [POS_W-1:0]      idx_base;
    logic                  code_ok;
    logic [1:0]            code;
    logic                  kmer;
    logic [POS_W-1:0]      pos;
    logic [31:0]           div_prod;
    logic [12:0]           quot;
    logic [POS_W-1:0]      quot_x10;
    logic                  sampled;
    logic                  accept;

    // Take a new base when no clear is running and the job slot is free or drains this cycle
    assign i_in.ready = !i_stat.clr_busy && (!r_job_valid || i_stat.job_take);
    assign accept     = i_in.valid && i_in.ready;

    // Clamp the k-mer length and build the key mask
    always_comb begin
        if (r_kmer_len < KMER_LEN_MIN) begin
            k_eff = KMER_LEN_MIN;
        end else if (r_kmer_len > KMER_LEN_MAX) begin
            k_eff = KMER_LEN_MAX;
        end else begin
            k_eff = r_kmer_len;
        end
        two_k    = {k_eff, 1'b0};
        key_mask = {KEY_W{1'b1}} >> (7'd64 - two_k);
    end

    // Decode the base character
    always_comb begin
        unique case (i_in.base_char)
            CHAR_A: begin
                code_ok = 1'b1;
                code    = CODE_A;
            end
            CHAR_T: begin
                code_ok = 1'b1;
                code    = CODE_T;
            end
            CHAR_C: begin
                code_ok = 1'b1;
                code    = CODE_C;
            end
            CHAR_G: begin
                code_ok = 1'b1;
                code    = CODE_G;
            end
            default: begin
                code_ok = 1'b0;
                code    = CODE_A;
            end
        endcase
    end

    // Advance the rolling key, run length and base index
    always_comb begin
        key_base = i_in.read_start ? '0 : r_rolling_key;
        run_base = i_in.read_start ? '0 : r_valid_run;
        idx_base = i_in.read_start ? '0 : r_base_index;

        n_base_index = (idx_base == POS_MAX) ? POS_MAX : idx_base + 16'd1;

        if (code_ok) begin
            n_rolling_key = ((key_base << 2) | {62'd0, code}) & key_mask;
            n_valid_run   = (run_base < k_eff) ? run_base + 6'd1 : k_eff;
        end else begin
            n_rolling_key = '0;
            n_valid_run   = '0;
        end

        kmer = code_ok && (n_valid_run >= k_eff);
    end

    // Start position of the k-mer and the sampling flag
    always_comb begin
        pos      = (idx_base == POS_MAX) ? POS_MAX
                                         : idx_base - (16'(k_eff) - 16'd1);
        div_prod = 32'(pos) * DIV10_MUL;
        quot     = div_prod[31:DIV10_SHIFT];
        quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
        sampled  = (pos <= SAMPLE_EVERY) || (pos == quot_x10);

        n_job.kmer    = kmer;
        n_job.query   = i_in.func;
        n_job.key     = kmer ? n_rolling_key : '0;
        n_job.pos     = kmer ? pos : '0;
        n_job.sampled = kmer && sampled;
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len    <= KMER_LEN_RESET;
            r_rolling_key <= '0;
            r_valid_run   <= '0;
            r_base_index  <= '0;
            r_job_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_kmer_len <= i_cfg_wdata;
            end
            if (accept) begin
                r_rolling_key <= n_rolling_key;
                r_valid_run   <= n_valid_run;
                r_base_index  <= n_base_index;
                r_job_valid   <= 1'b1;
            end else if (i_stat.job_take) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    // Hold the job word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

endmodule

// File: rtl/kbf_probe.sv
`include "kmer_bloom_filter_core_assert.svh"

module kbf_probe
    import kbf_pkg::*;
#(
    parameter int ADDR_W = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  t_job                i_job,
    input  logic [OQ_CNT_W-1:0] i_oq_count,
    output t_probe_stat         o_stat,
    output logic                o_push,
    output t_res                o_res
);

    localparam int ROW_W = ADDR_W - ROW_OFS_BITS;
    localparam int DEPTH = 1 << ROW_W;

    // Filter memory and its clearing pass
    logic [ROW_BITS-1:0] r_mem [DEPTH];
    logic [ROW_BITS-1:0] r_rd_row;
    logic                r_clr_busy;
    logic [ROW_W-1:0]    r_clr_row;

    // Probe sequencer
    t_probe_idx          r_probe_idx;

    // Issue stage (address registered after the multiply)
    logic                r_s1_valid;
    logic                r_s1_probe;
    logic                r_s1_first;
    logic                r_s1_last;
    logic [ADDR_W-1:0]   r_s1_addr;
    t_job                r_s1_job;

    // Read data stage
    logic                r_s2_valid;
    logic                r_s2_probe;
    logic                r_s2_first;
    logic                r_s2_last;
    logic [ADDR_W-1:0]   r_s2_addr;
    t_job                r_s2_job;

    // Last write, for forwarding into the next read
    logic                r_fw_valid;
    logic [ROW_W-1:0]    r_fw_row;
    logic [ROW_BITS-1:0] r_fw_data;
    logic                r_hit;

    logic [OQ_CNT_W-1:0]     inflight;
    logic                    can_issue;
    logic                    issue_last;
    logic [ADDR_W-1:0]       mult;
    logic [ADDR_W-1:0]       n_addr;
    logic [ROW_W-1:0]        s2_row;
    logic [ROW_OFS_BITS-1:0] s2_ofs;
    logic [ROW_BITS-1:0]     row_cur;
    logic                    probe_bit;
    logic                    hit_now;
    logic                    s2_write;
    logic [ROW_BITS-1:0]     wr_row;
    logic                    mem_we;
    logic [ROW_W-1:0]        mem_wa;
    logic [ROW_BITS-1:0]     mem_wd;

    // Issue only with room in the output queue for every word in flight
    always_comb begin
        inflight   = i_oq_count
                   + OQ_CNT_W'(r_s1_valid && r_s1_last)
                   + OQ_CNT_W'(r_s2_valid && r_s2_last);
        can_issue  = !r_clr_busy && i_job_valid && (inflight < OQ_CNT_W'(OQ_DEPTH));
        issue_last = !i_job.kmer || (r_probe_idx == PROBE_LAST);
        mult       = ADDR_W'(hash_mult(r_probe_idx));
        n_addr     = i_job.key[ADDR_W-1:0] * mult;
    end

    assign o_stat.job_take = can_issue && issue_last;
    assign o_stat.clr_busy = r_clr_busy;

    // Test and set the probed bit, forwarding the row written last cycle
    always_comb begin
        s2_row    = r_s2_addr[ADDR_W-1:ROW_OFS_BITS];
        s2_ofs    = r_s2_addr[ROW_OFS_BITS-1:0];
        row_cur   = (r_fw_valid && (r_fw_row == s2_row)) ? r_fw_data : r_rd_row;
        probe_bit = row_cur[s2_ofs];
        hit_now   = (r_s2_first || r_hit) && probe_bit;
        s2_write  = r_s2_valid && r_s2_probe && !r_s2_job.query;
        wr_row    = row_cur | (ROW_BITS'(1) << s2_ofs);

        mem_we = r_clr_busy || s2_write;
        mem_wa = r_clr_busy ? r_clr_row : s2_row;
        mem_wd = r_clr_busy ? '0 : wr_row;
    end

    // Emit the result word with the last token of each base
    always_comb begin
        o_push              = r_s2_valid && r_s2_last;
        o_res.kmer_ready    = r_s2_job.kmer;
        o_res.kmer_key      = r_s2_job.key;
        o_res.kmer_pos      = r_s2_job.pos;
        o_res.sampled       = r_s2_job.sampled;
        o_res.maybe_present = r_s2_job.kmer && r_s2_job.query && hit_now;
    end

    // Control: clearing pass, sequencer, stage valids, forwarding valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_row   <= '0;
            r_probe_idx <= PROBE_FIRST;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_row == '1) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_row <= r_clr_row + ROW_W'(1);
                end
            end
            if (can_issue && i_job.kmer) begin
                r_probe_idx <= issue_last ? PROBE_FIRST : r_probe_idx + 2'd1;
            end
            r_s1_valid <= can_issue;
            r_s2_valid <= r_s1_valid;
            r_fw_valid <= s2_write;
        end
    end

    // Advance the stage payloads
    always_ff @(posedge i_clk) begin
        r_s1_probe <= i_job.kmer;
        r_s1_first <= (r_probe_idx == PROBE_FIRST);
        r_s1_last  <= issue_last;
        r_s1_addr  <= n_addr;
        r_s1_job   <= i_job;

        r_s2_probe <= r_s1_probe;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_addr  <= r_s1_addr;
        r_s2_job   <= r_s1_job;

        r_fw_row   <= s2_row;
        r_fw_data  <= wr_row;
        if (r_s2_valid && r_s2_probe) begin
            r_hit <= hit_now;
        end
    end

    // Filter memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_row <= r_mem[r_s1_addr[ADDR_W-1:ROW_OFS_BITS]];
    end

    `KBF_ASSERT_IMPL(a_clr_no_take, r_clr_busy, !o_stat.job_take, "base taken during clear")
    `KBF_ASSERT_IMPL(a_clr_full_sweep, $fell(r_clr_busy), $past(r_clr_row) == '1, "short clear")
    `KBF_ASSERT_IMPL(a_s2_from_s1, r_s2_valid, $past(r_s1_valid), "token skipped a stage")

endmodule

// File: rtl/kbf_outq.sv
`include "kmer_bloom_filter_core_assert.svh"

module kbf_outq
    import kbf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_res                i_res,
    output logic [OQ_CNT_W-1:0] o_count,
    kbf_out_if.source           o_out
);

    t_res                r_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wp;
    logic [OQ_PTR_W-1:0] r_rp;
    logic [OQ_CNT_W-1:0] r_count;
    logic                pop;
    t_res                head;

    // Present the oldest word
    assign head                = r_q[r_rp];
    assign o_out.valid         = (r_count != '0);
    assign o_out.kmer_ready    = head.kmer_ready;
    assign o_out.kmer_key      = head.kmer_key;
    assign o_out.kmer_pos      = head.kmer_pos;
    assign o_out.sampled       = head.sampled;
    assign o_out.maybe_present = head.maybe_present;
    assign pop                 = o_out.valid && o_out.ready;
    assign o_count             = r_count;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + OQ_PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + OQ_PTR_W'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + OQ_CNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - OQ_CNT_W'(1);
            end
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_res;
        end
    end

    `KBF_ASSERT_IMPL(a_oq_no_overflow, r_count == OQ_CNT_W'(OQ_DEPTH), !i_push, "queue overflow")
    `KBF_ASSERT(a_oq_count_max, r_count <= OQ_CNT_W'(OQ_DEPTH), "queue count out of range")
    `KBF_ASSERT(a_oq_ptr_count, OQ_PTR_W'(r_wp - r_rp) == OQ_PTR_W'(r_count), "pointer mismatch")

endmodule

// File: rtl/kmer_bloom_filter_core.sv
// Channel     Dir  Word
// i_in_ch     in   func, base_char, read_start (valid/ready)
// o_out_ch    out  kmer_ready, kmer_key, kmer_pos, sampled, maybe_present (valid/ready)
// i_cfg_*     in   kmer_len, written when i_cfg_we is high
//
// A base that completes no k-mer is issued once; one that completes a k-mer is issued once
// per hash probe, through the single write and single read port of the filter memory.
// From input accept, a result word passes the front-end job register, the issue stage,
// the read data stage and the output queue before it can be accepted at the output.
// Reset is synchronous; afterwards the filter is swept clear, all 2^(FILTER_ADDR_BITS-6)
// rows, one 64-bit row per cycle, with i_in_ch.ready low.
// A stalled output fills a 4-word queue, then holds off new probes and input.
module kmer_bloom_filter_core
    import kbf_pkg::*;
#(
    parameter int FILTER_ADDR_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [KMER_LEN_W-1:0] i_cfg_wdata,
    kbf_in_if.sink                i_in_ch,
    kbf_out_if.source             o_out_ch
);

    logic                job_valid;
    t_job                job;
    t_probe_stat         stat;
    logic [OQ_CNT_W-1:0] oq_count;
    logic                push;
    t_res                res;

    // Rolling key and k-mer detection
    kbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stat      (stat),
        .i_in        (i_in_ch),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // Hash probes against the filter memory
    kbf_probe #(
        .ADDR_W (FILTER_ADDR_BITS)
    ) u_probe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .i_oq_count  (oq_count),
        .o_stat      (stat),
        .o_push      (push),
        .o_res       (res)
    );

    // Result queue toward the output channel
    kbf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_count (oq_count),
        .o_out   (o_out_ch)
    );

endmodule
